/* rtl/scc_pkg.sv */
// ============================================================================
// scc_pkg
// Shared types and constants for the strongly connected sink count block.
// ============================================================================
package scc_pkg;

    // Default capacities
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    // Fixed widths of the port fields
    localparam int FIELD_W = 11;
    localparam int OUT_W   = 11;

    // Input operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_ROOT,
        S_STEP,
        S_EDGE,
        S_NBR,
        S_FIN,
        S_POPA,
        S_POPB,
        S_POPC,
        S_RET,
        S_PARENT,
        S_XSCAN,
        S_XNODE,
        S_XE,
        S_XED,
        S_XW,
        S_SUMRD,
        S_SUMUSE,
        S_DONE
    } state_t;

    // Result handed from the engine to the output register
    typedef struct packed {
        logic [OUT_W-1:0] popular_count;
        logic [OUT_W-1:0] component_count;
        logic [OUT_W-1:0] sink_count;
        logic             edges_dropped;
    } result_t;

endpackage

/* rtl/strongly_connected_sink_count_top.sv */
// ============================================================================
// strongly_connected_sink_count_top
// Edge collector and strongly connected component / sink counter.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall, op/src/dst): op add stores one edge
//   per transfer, one transfer per cycle while in_stall is low. Edges with
//   an endpoint outside 1..MAX_NODES are ignored; edges past MAX_EDGES set
//   edges_dropped. op finish starts the component search over nodes
//   1..node_count. Output channel (out_valid/out_stall): one result per
//   finish item. After a result is loaded into the output register, a
//   clearing pass resets the node RAM; the same pass runs after reset.
//   in_stall stays high during search and clearing. A stalled result holds
//   in the output register; the clearing pass and the next edges proceed
//   meanwhile, and the next result waits. cfg_we/cfg_data write node_count
//   (reset value 1); the user must write it only while the block idles,
//   the block itself does not enforce it.
// ============================================================================
module strongly_connected_sink_count_top
    import scc_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [FIELD_W-1:0] src,
    input  logic [FIELD_W-1:0] dst,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [OUT_W-1:0]   popular_count,
    output logic [OUT_W-1:0]   component_count,
    output logic [OUT_W-1:0]   sink_count,
    output logic               edges_dropped
);

    logic    res_valid, res_ready;
    result_t res;
    logic    out_valid_reg;
    result_t out_reg;

    scc_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .src(src), .dst(dst),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    // Take a new result once the output register is free
    assign res_ready = !out_valid_reg || !out_stall;

    // Output register: load, hold while stalled, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign popular_count   = out_reg.popular_count;
    assign component_count = out_reg.component_count;
    assign sink_count      = out_reg.sink_count;
    assign edges_dropped   = out_reg.edges_dropped;

endmodule

/* rtl/scc_ram.sv */
// ============================================================================
// scc_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ============================================================================
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/scc_engine.sv */
// ============================================================================
// scc_engine
// Edge loader and component search sequencer. Adjacency lists, node records,
// both stacks and component records live in synchronous RAMs.
// ============================================================================
module scc_engine
    import scc_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [FIELD_W-1:0] src,
    input  logic [FIELD_W-1:0] dst,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam int NW      = $clog2(MAX_NODES);
    localparam int DW      = $clog2(MAX_NODES + 1);
    localparam int EIW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EPW     = $clog2(MAX_EDGES + 1);
    localparam int NREC_W  = EPW + DW + NW + 1;
    localparam int EREC_W  = NW + EPW;
    localparam int FRAME_W = NW + EPW + 2 * DW;
    localparam logic [EPW-1:0] NO_EDGE   = EPW'(MAX_EDGES);
    localparam logic [NW-1:0]  LAST_NODE = NW'(MAX_NODES - 1);

    state_t state_reg, state_next;

    logic [FIELD_W-1:0] ncount_reg;
    logic [DW-1:0]  n_reg, i_reg, vc_reg, cc_reg, ctop_reg, ktop_reg;
    logic [DW-1:0]  cur_disc_reg, cur_low_reg, sz_reg, k_reg, sinks_reg, pop_reg;
    logic [NW-1:0]  cur_u_reg, vnode_reg, ci_reg, clr_reg;
    logic [EPW-1:0] cur_e_reg, ec_reg;
    logic           ovf_reg;
    logic           p_valid_reg, w_valid_reg;
    logic [NW-1:0]  p_src_reg, p_dst_reg, w_src_reg;
    logic [EPW-1:0] p_ec_reg, w_ec_reg;

    // RAM ports
    logic               n_we, e_we, c_we, k_we, s_we, x_we;
    logic [NW-1:0]      n_waddr, n_raddr, c_waddr, c_raddr, k_waddr, k_raddr;
    logic [NW-1:0]      s_waddr, x_waddr, g_raddr;
    logic [EIW-1:0]     e_waddr, e_raddr;
    logic [NREC_W-1:0]  n_wdata, n_rdata;
    logic [EREC_W-1:0]  e_wdata, e_rdata;
    logic [NW-1:0]      c_wdata, c_rdata;
    logic [FRAME_W-1:0] k_wdata, k_rdata;
    logic [DW-1:0]      s_wdata, s_rdata;
    logic               x_wdata, x_rdata;

    // Unpacked read words
    logic [EPW-1:0] nrd_first;
    logic [DW-1:0]  nrd_disc;
    logic [NW-1:0]  nrd_comp;
    logic           nrd_onstk;
    logic [NW-1:0]  e_w;
    logic [EPW-1:0] e_link;
    logic [NW-1:0]  f_node;
    logic [EPW-1:0] f_edge;
    logic [DW-1:0]  f_disc, f_low;

    logic           accept, src_ok, dst_ok, edge_ok, store_edge;
    logic [NW-1:0]  src_idx, dst_idx;
    logic           visit_now, w_in, pop_last;
    logic [DW-1:0]  vc_inc, n_calc;
    logic [EPW-1:0] p_link;

    assign nrd_first = n_rdata[NREC_W-1 -: EPW];
    assign nrd_disc  = n_rdata[DW+NW -: DW];
    assign nrd_comp  = n_rdata[NW -: NW];
    assign nrd_onstk = n_rdata[0];
    assign e_w       = e_rdata[EREC_W-1 -: NW];
    assign e_link    = e_rdata[EPW-1:0];
    assign f_node    = k_rdata[FRAME_W-1 -: NW];
    assign f_edge    = k_rdata[2*DW+EPW-1 -: EPW];
    assign f_disc    = k_rdata[2*DW-1 -: DW];
    assign f_low     = k_rdata[DW-1:0];

    // Input decode
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign src_ok     = (src != '0) && (32'(src) <= 32'(MAX_NODES));
    assign dst_ok     = (dst != '0) && (32'(dst) <= 32'(MAX_NODES));
    assign src_idx    = NW'(32'(src) - 32'd1);
    assign dst_idx    = NW'(32'(dst) - 32'd1);
    assign edge_ok    = (op == OP_ADD) && src_ok && dst_ok;
    assign store_edge = accept && edge_ok && (ec_reg != NO_EDGE);

    // Forward the head pointer written by the previous edge (w stage) for a repeated source
    assign p_link = (w_valid_reg && (w_src_reg == p_src_reg)) ? w_ec_reg : nrd_first;

    assign visit_now = ((state_reg == S_ROOT) || (state_reg == S_NBR)) && (nrd_disc == '0);
    assign w_in      = 32'(e_w) < 32'(n_reg);
    assign pop_last  = (vnode_reg == cur_u_reg);
    assign vc_inc    = vc_reg + DW'(1);

    // Clamp the node count register into the usable range
    always_comb
    begin
        if (ncount_reg == '0)
        begin
            n_calc = DW'(1);
        end
        else if (32'(ncount_reg) > 32'(MAX_NODES))
        begin
            n_calc = DW'(MAX_NODES);
        end
        else
        begin
            n_calc = DW'(ncount_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_reg == LAST_NODE) state_next = S_IDLE;
            S_IDLE:   if (accept && (op == OP_FINISH)) state_next = S_SETUP;
            S_SETUP:  state_next = S_SCAN;
            S_SCAN:   state_next = (i_reg == n_reg) ? S_XSCAN : S_ROOT;
            S_ROOT:   state_next = visit_now ? S_STEP : S_SCAN;
            S_STEP:   state_next = (cur_e_reg != NO_EDGE) ? S_EDGE : S_FIN;
            S_EDGE:   state_next = w_in ? S_NBR : S_STEP;
            S_NBR:    state_next = S_STEP;
            S_FIN:    state_next = (cur_low_reg == cur_disc_reg) ? S_POPA : S_RET;
            S_POPA:   state_next = S_POPB;
            S_POPB:   state_next = S_POPC;
            S_POPC:   state_next = pop_last ? S_RET : S_POPA;
            S_RET:    state_next = (ktop_reg > DW'(1)) ? S_PARENT : S_SCAN;
            S_PARENT: state_next = S_STEP;
            S_XSCAN:  state_next = (i_reg == n_reg) ? S_SUMRD : S_XNODE;
            S_XNODE:  state_next = S_XE;
            S_XE:     state_next = (cur_e_reg == NO_EDGE) ? S_XSCAN : S_XED;
            S_XED:    state_next = w_in ? S_XW : S_XE;
            S_XW:     state_next = S_XE;
            S_SUMRD:  state_next = (k_reg == cc_reg) ? S_DONE : S_SUMUSE;
            S_SUMUSE: state_next = S_SUMRD;
            S_DONE:   if (res_ready) state_next = S_CLEAR;
            default:  state_next = S_CLEAR;
        endcase
    end

    // Memory controls and result
    always_comb
    begin
        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = src_idx;
        e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = cur_e_reg[EIW-1:0];
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = NW'(ctop_reg - DW'(1));
        k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_raddr = NW'(ktop_reg - DW'(2));
        s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        x_we = 1'b0; x_waddr = '0; x_wdata = 1'b0;
        g_raddr = k_reg[NW-1:0];

        unique case (state_reg)
            S_SCAN, S_XSCAN:
            begin
                n_raddr = i_reg[NW-1:0];
            end
            S_EDGE, S_XED:
            begin
                n_raddr = e_w;
            end
            S_POPB:
            begin
                n_raddr = c_rdata;
            end
            S_POPC:
            begin
                n_we    = 1'b1;
                n_waddr = vnode_reg;
                n_wdata = {nrd_first, nrd_disc, cc_reg[NW-1:0], 1'b0};
                if (pop_last)
                begin
                    s_we    = 1'b1;
                    s_waddr = cc_reg[NW-1:0];
                    s_wdata = sz_reg + DW'(1);
                    x_we    = 1'b1;
                    x_waddr = cc_reg[NW-1:0];
                    x_wdata = 1'b0;
                end
            end
            S_XW:
            begin
                if (nrd_comp != ci_reg)
                begin
                    x_we    = 1'b1;
                    x_waddr = ci_reg;
                    x_wdata = 1'b1;
                end
            end
            S_CLEAR:
            begin
                n_we    = 1'b1;
                n_waddr = clr_reg;
                n_wdata = {NO_EDGE, {DW{1'b0}}, {NW{1'b0}}, 1'b0};
            end
            default:
            begin
            end
        endcase

        // Visit a fresh node: mark it, push it, save the caller frame
        if (visit_now)
        begin
            n_we    = 1'b1;
            n_waddr = vnode_reg;
            n_wdata = {nrd_first, vc_inc, nrd_comp, 1'b1};
            c_we    = 1'b1;
            c_waddr = ctop_reg[NW-1:0];
            c_wdata = vnode_reg;
            if (ktop_reg != '0)
            begin
                k_we    = 1'b1;
                k_waddr = NW'(ktop_reg - DW'(1));
                k_wdata = {cur_u_reg, cur_e_reg, cur_disc_reg, cur_low_reg};
            end
        end

        // Second half of an edge transfer: link and write the list head
        if (p_valid_reg)
        begin
            n_we    = 1'b1;
            n_waddr = p_src_reg;
            n_wdata = {p_ec_reg, {DW{1'b0}}, {NW{1'b0}}, 1'b0};
            e_we    = 1'b1;
            e_waddr = p_ec_reg[EIW-1:0];
            e_wdata = {p_dst_reg, p_link};
        end

        res_valid           = (state_reg == S_DONE);
        res.popular_count   = (sinks_reg > DW'(1)) ? '0 : OUT_W'(pop_reg);
        res.component_count = OUT_W'(cc_reg);
        res.sink_count      = OUT_W'(sinks_reg);
        res.edges_dropped   = ovf_reg;
    end

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ncount_reg   <= FIELD_W'(1);
            n_reg        <= '0;
            i_reg        <= '0;
            vc_reg       <= '0;
            cc_reg       <= '0;
            ctop_reg     <= '0;
            ktop_reg     <= '0;
            cur_disc_reg <= '0;
            cur_low_reg  <= '0;
            sz_reg       <= '0;
            k_reg        <= '0;
            sinks_reg    <= '0;
            pop_reg      <= '0;
            cur_u_reg    <= '0;
            vnode_reg    <= '0;
            ci_reg       <= '0;
            clr_reg      <= '0;
            cur_e_reg    <= '0;
            ec_reg       <= '0;
            ovf_reg      <= 1'b0;
            p_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            p_src_reg    <= '0;
            p_dst_reg    <= '0;
            p_ec_reg     <= '0;
            w_src_reg    <= '0;
            w_ec_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                ncount_reg <= cfg_data;
            end

            // Edge transfer pipeline
            p_valid_reg <= store_edge;
            if (store_edge)
            begin
                p_src_reg <= src_idx;
                p_dst_reg <= dst_idx;
                p_ec_reg  <= ec_reg;
                ec_reg    <= ec_reg + EPW'(1);
            end
            if (accept && edge_ok && (ec_reg == NO_EDGE))
            begin
                ovf_reg <= 1'b1;
            end
            w_valid_reg <= p_valid_reg;
            w_src_reg   <= p_src_reg;
            w_ec_reg    <= p_ec_reg;

            if (visit_now)
            begin
                vc_reg       <= vc_inc;
                ctop_reg     <= ctop_reg + DW'(1);
                ktop_reg     <= ktop_reg + DW'(1);
                cur_u_reg    <= vnode_reg;
                cur_e_reg    <= nrd_first;
                cur_disc_reg <= vc_inc;
                cur_low_reg  <= vc_inc;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (op == OP_FINISH))
                    begin
                        n_reg <= n_calc;
                        i_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (i_reg == n_reg)
                    begin
                        i_reg <= '0;
                    end
                    else
                    begin
                        vnode_reg <= i_reg[NW-1:0];
                    end
                end
                S_ROOT:
                begin
                    if (!visit_now)
                    begin
                        i_reg <= i_reg + DW'(1);
                    end
                end
                S_EDGE:
                begin
                    cur_e_reg <= e_link;
                    vnode_reg <= e_w;
                end
                S_NBR:
                begin
                    if (!visit_now && nrd_onstk && (nrd_disc < cur_low_reg))
                    begin
                        cur_low_reg <= nrd_disc;
                    end
                end
                S_FIN:
                begin
                    sz_reg <= '0;
                end
                S_POPA:
                begin
                    ctop_reg <= ctop_reg - DW'(1);
                end
                S_POPB:
                begin
                    vnode_reg <= c_rdata;
                end
                S_POPC:
                begin
                    sz_reg <= sz_reg + DW'(1);
                    if (pop_last)
                    begin
                        cc_reg <= cc_reg + DW'(1);
                    end
                end
                S_RET:
                begin
                    ktop_reg <= ktop_reg - DW'(1);
                    if (ktop_reg <= DW'(1))
                    begin
                        i_reg <= i_reg + DW'(1);
                    end
                end
                S_PARENT:
                begin
                    cur_u_reg    <= f_node;
                    cur_e_reg    <= f_edge;
                    cur_disc_reg <= f_disc;
                    cur_low_reg  <= (cur_low_reg < f_low) ? cur_low_reg : f_low;
                end
                S_XSCAN:
                begin
                    if (i_reg == n_reg)
                    begin
                        k_reg     <= '0;
                        sinks_reg <= '0;
                        pop_reg   <= '0;
                    end
                end
                S_XNODE:
                begin
                    ci_reg    <= nrd_comp;
                    cur_e_reg <= nrd_first;
                end
                S_XE:
                begin
                    if (cur_e_reg == NO_EDGE)
                    begin
                        i_reg <= i_reg + DW'(1);
                    end
                end
                S_XED:
                begin
                    cur_e_reg <= e_link;
                end
                S_SUMUSE:
                begin
                    if (!x_rdata)
                    begin
                        sinks_reg <= sinks_reg + DW'(1);
                        pop_reg   <= s_rdata;
                    end
                    k_reg <= k_reg + DW'(1);
                end
                S_DONE:
                begin
                    clr_reg <= '0;
                end
                S_CLEAR:
                begin
                    clr_reg  <= clr_reg + NW'(1);
                    ec_reg   <= '0;
                    ovf_reg  <= 1'b0;
                    vc_reg   <= '0;
                    cc_reg   <= '0;
                    ctop_reg <= '0;
                    ktop_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Node records: list head, discovery index, component, on-stack flag
    scc_ram #(.WIDTH(NREC_W), .DEPTH(MAX_NODES), .AW(NW)) u_node_mem (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    // Edge records: target and next link
    scc_ram #(.WIDTH(EREC_W), .DEPTH(MAX_EDGES), .AW(EIW)) u_edge_mem (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    // Component stack
    scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES), .AW(NW)) u_comp_stack (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    // Call stack frames below the cached top frame
    scc_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_NODES), .AW(NW)) u_call_stack (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    // Component sizes
    scc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES), .AW(NW)) u_size_mem (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(g_raddr), .rdata(s_rdata)
    );

    // Component exit flags
    scc_ram #(.WIDTH(1), .DEPTH(MAX_NODES), .AW(NW)) u_exit_mem (
        .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
        .raddr(g_raddr), .rdata(x_rdata)
    );

endmodule

/* rtl/scc_checker.sv */
// ============================================================================
// scc_checker
// Port-level checks for the strongly connected sink count block.
// ============================================================================
module scc_checker
    import scc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               op,
    input logic               out_valid,
    input logic               out_stall,
    input logic [OUT_W-1:0]   popular_count,
    input logic [OUT_W-1:0]   component_count,
    input logic [OUT_W-1:0]   sink_count,
    input logic               edges_dropped
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(popular_count)
        && $stable(component_count) && $stable(sink_count) && $stable(edges_dropped))
        else $error("stalled result changed");

    // A finish transfer starts the search and blocks input
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_FINISH |=> in_stall)
        else $error("input not stalled after finish");

    // At least one component and one sink, never more sinks than components
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> component_count != '0 && sink_count != '0
        && sink_count <= component_count)
        else $error("inconsistent component and sink counts");

    // Several sinks leave no popular component
    a_popular: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sink_count > OUT_W'(1) |-> popular_count == '0)
        else $error("popular count with several sinks");

endmodule

bind strongly_connected_sink_count_top scc_checker u_scc_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .out_valid(out_valid), .out_stall(out_stall),
    .popular_count(popular_count), .component_count(component_count),
    .sink_count(sink_count), .edges_dropped(edges_dropped)
);
